// ===== src/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find/replace block
// Command and status bundles between controller and datapath, state codes,
// configuration register indexes and widths.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned CFG_IW    = 2;
  localparam int unsigned LEN_W     = 4;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  // Source of an emitted byte
  typedef enum logic [1:0] {
    SRC_FRONT = 2'd0,
    SRC_INPUT = 2'd1,
    SRC_REPL  = 2'd2
  } emit_src_t;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FLUSH = 7'b0000010,
    S_INS   = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_REP   = 7'b0010000,
    S_END   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic      load;       // capture the incoming transaction
    logic      clr_stale;  // held bytes now belong to the current pattern
    logic      emit;       // produce one result byte
    emit_src_t src;        // where the emitted byte comes from
    logic      pop;        // drop the front held byte
    logic      append;     // append the captured byte to the held bytes
    logic      clr_count;  // discard held bytes after a match
    logic      rep_start;  // restart the replacement index
    logic      rep_adv;    // advance the replacement index
    logic      fin;        // close the item: push pending result or end marker
  } cmd_t;

  typedef struct packed {
    logic stale;
    logic plen_zero;
    logic cnt_zero;
    logic cnt_ge_plen;
    logic cnt_eq_plen;
    logic prefix;
    logic rep_more;
    logic end_flag;
    logic pend_v;
    logic emit_ok;
    logic out_free;
  } sts_t;

endpackage

// ===== src/sfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_ctrl: sequencing controller
// Walks one accepted transaction through flush, insert, check, replace and
// end phases, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module sfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sfr_pkg::sts_t sts,
  output sfr_pkg::cmd_t cmd
);
  import sfr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.src   = SRC_FRONT;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FLUSH;
        end
      end
      // release bytes of an old pattern, or everything in pass-through
      S_FLUSH: begin
        if ((sts.stale || sts.plen_zero) && !sts.cnt_zero) begin
          if (sts.emit_ok) begin
            cmd.emit = 1'b1;
            cmd.pop  = 1'b1;
          end
        end else begin
          cmd.clr_stale = 1'b1;
          state_nxt     = S_INS;
        end
      end
      S_INS: begin
        if (sts.plen_zero) begin
          if (sts.emit_ok) begin
            cmd.emit  = 1'b1;
            cmd.src   = SRC_INPUT;
            state_nxt = S_END;
          end
        end else if (sts.cnt_ge_plen) begin
          if (sts.emit_ok) begin
            cmd.emit = 1'b1;
            cmd.pop  = 1'b1;
          end
        end else begin
          cmd.append = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.cnt_eq_plen && sts.prefix) begin
          cmd.clr_count = 1'b1;
          cmd.rep_start = 1'b1;
          state_nxt     = S_REP;
        end else if (!sts.cnt_zero && !sts.prefix) begin
          if (sts.emit_ok) begin
            cmd.emit = 1'b1;
            cmd.pop  = 1'b1;
          end
        end else begin
          state_nxt = S_END;
        end
      end
      S_REP: begin
        if (sts.rep_more) begin
          if (sts.emit_ok) begin
            cmd.emit    = 1'b1;
            cmd.src     = SRC_REPL;
            cmd.rep_adv = 1'b1;
          end
        end else begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (sts.end_flag && !sts.cnt_zero) begin
          if (sts.emit_ok) begin
            cmd.emit = 1'b1;
            cmd.pop  = 1'b1;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free || !(sts.pend_v || sts.end_flag)) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sfr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_dp: find/replace datapath
// Configuration registers, held-byte buffer with prefix compare,
// replacement index, one-entry pending result and the output register.
// ----------------------------------------------------------------------------
module sfr_dp #(
  parameter int unsigned MAX_PATTERN     = 8,
  parameter int unsigned MAX_REPLACEMENT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sfr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic [sfr_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_end,
  output logic [sfr_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_has_byte,
  output logic                         out_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  sfr_pkg::cmd_t                cmd,
  output sfr_pkg::sts_t                sts
);
  import sfr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RW = $clog2(MAX_REPLACEMENT + 1);
  localparam logic [LEN_W-1:0] PLEN_CAP = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W-1:0] RLEN_CAP = LEN_W'(MAX_REPLACEMENT);

  // configuration
  logic [CFG_DW-1:0] pat_bytes_r, rep_bytes_r;
  logic [LEN_W-1:0]  pat_len_r, rep_len_r;
  logic              stale_r;

  // item and buffer state
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_end_r;
  logic [BYTE_W-1:0] held_r [MAX_PATTERN];
  logic [CW-1:0]     cnt_r;
  logic [RW-1:0]     ridx_r;

  // pending result and output register
  logic [BYTE_W-1:0] pend_byte_r;
  logic              pend_v_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_has_r, out_last_r, out_v_r;

  logic [LEN_W-1:0]  plen, rlen;
  logic              prefix;
  logic [BYTE_W-1:0] rep_byte, emit_byte;
  logic              out_free, out_load;

  assign plen = (pat_len_r > PLEN_CAP) ? PLEN_CAP : pat_len_r;
  assign rlen = (rep_len_r > RLEN_CAP) ? RLEN_CAP : rep_len_r;

  always_comb begin
    prefix = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CW'(i) < cnt_r) && (held_r[i] != pat_bytes_r[BYTE_W*i +: BYTE_W])) begin
        prefix = 1'b0;
      end
    end
  end

  always_comb begin
    rep_byte = '0;
    for (int i = 0; i < MAX_REPLACEMENT; i++) begin
      if (ridx_r == RW'(i)) begin
        rep_byte = rep_bytes_r[BYTE_W*i +: BYTE_W];
      end
    end
  end

  always_comb begin
    case (cmd.src)
      SRC_FRONT: emit_byte = held_r[0];
      SRC_INPUT: emit_byte = in_byte_r;
      SRC_REPL:  emit_byte = rep_byte;
      default:   emit_byte = held_r[0];
    endcase
  end

  assign out_free = !out_v_r || out_ready;
  // a new byte pushes the pending one out; closing the item pushes it last
  assign out_load = (cmd.emit && pend_v_r) || (cmd.fin && (pend_v_r || in_end_r));

  always_comb begin
    sts.stale       = stale_r;
    sts.plen_zero   = (plen == '0);
    sts.cnt_zero    = (cnt_r == '0);
    sts.cnt_ge_plen = (LEN_W'(cnt_r) >= plen);
    sts.cnt_eq_plen = (LEN_W'(cnt_r) == plen);
    sts.prefix      = prefix;
    sts.rep_more    = (LEN_W'(ridx_r) < rlen);
    sts.end_flag    = in_end_r;
    sts.pend_v      = pend_v_r;
    sts.emit_ok     = !pend_v_r || out_free;
    sts.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= '0;
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
      stale_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATTERN_BYTES: begin
          pat_bytes_r <= cfg_wdata;
          stale_r     <= 1'b1;
        end
        CFG_PATTERN_LENGTH: begin
          pat_len_r <= cfg_wdata[LEN_W-1:0];
          stale_r   <= 1'b1;
        end
        CFG_REPLACEMENT_BYTES:  rep_bytes_r <= cfg_wdata;
        CFG_REPLACEMENT_LENGTH: rep_len_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end else if (cmd.clr_stale) begin
      stale_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_byte_r <= in_byte;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (cmd.pop) begin
        if (i < MAX_PATTERN - 1) begin
          held_r[i] <= held_r[(i < MAX_PATTERN - 1) ? i + 1 : i];
        end
      end else if (cmd.append && (cnt_r == CW'(i))) begin
        held_r[i] <= in_byte_r;
      end
    end
    if (cmd.emit) begin
      pend_byte_r <= emit_byte;
    end
    if (out_load) begin
      out_byte_r <= pend_v_r ? pend_byte_r : '0;
      out_has_r  <= pend_v_r;
      out_last_r <= cmd.fin && in_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_end_r <= 1'b0;
      cnt_r    <= '0;
      ridx_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        in_end_r <= in_end;
      end
      if (cmd.clr_count) begin
        cnt_r <= '0;
      end else if (cmd.pop) begin
        cnt_r <= cnt_r - CW'(1);
      end else if (cmd.append) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.rep_start) begin
        ridx_r <= '0;
      end else if (cmd.rep_adv) begin
        ridx_r <= ridx_r + RW'(1);
      end
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
      end else if (cmd.fin) begin
        pend_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_byte     = out_byte_r;
  assign out_has_byte = out_has_r;
  assign out_last     = out_last_r;
  assign out_valid    = out_v_r;

endmodule

// ===== src/stream_find_replace.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace: streaming substring find and replace
// Rewrites a byte stream, replacing every leftmost non-overlapping match of
// a configured pattern (up to MAX_PATTERN bytes) with a configured
// replacement (up to MAX_REPLACEMENT bytes).
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Content
//  ---------+-----------+-----------------------------------------------------
//  in_      | slave     | tdata[7:0] text_byte, tlast text_end
//  out_     | master    | tdata[7:0] out_byte, tuser[0] out_has_byte, tlast out_last
//  cfg_     | write     | index 0 pattern, 1 pattern length,
//           |           | 2 replacement, 3 replacement length
//
//  Sequencing: one transaction at a time. With a pattern set, an input passes
//  through accept, flush, insert, check, end and finish, plus a release step for
//  every byte it releases; a match adds a replace phase for the replacement bytes.
//  In pass-through: accept, flush of any stale bytes, insert, end and finish.
//  The per-byte release/replace loop of the controller sets the rate.
//  Reset: rst_n synchronous, active low; clears config to zero (pass-through)
//  and empties the held-byte buffer.
//  Stalls: each result moves through a one-entry pending stage into the output
//  register; with both full and out_tready low, the controller holds its phase.
//  The final result of a text carries tlast; a text end that yields no byte
//  produces a lone end marker with tuser low.
//
module stream_find_replace #(
  parameter int unsigned MAX_PATTERN     = 8,
  parameter int unsigned MAX_REPLACEMENT = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration write port
  input  logic                       cfg_wr_en,
  input  logic [sfr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_DW-1:0] cfg_wdata,
  // input text stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] text_byte
  input  logic                       in_tlast,   // text_end
  // rewritten text stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic                       out_tuser,  // [0] out_has_byte
  output logic                       out_tlast   // out_last
);
  import sfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: steps each transaction through its phases
  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: config, held bytes, prefix compare and result staging
  sfr_dp #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_byte      (in_tdata),
    .in_end       (in_tlast),
    .out_byte     (out_tdata),
    .out_has_byte (out_tuser),
    .out_last     (out_tlast),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== tb/sv/stream_find_replace_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_test: self-checking bench for stream_find_replace
// Drives text bytes on the input stream and predicts the rewritten text in
// a behavioral model kept inside the bench. Every output transaction is
// compared field by field against the oldest predicted result. Covers pass
// through, matches at both length extremes, deletion, lone end markers,
// pattern changes in the middle of a text, output hold-off and random texts
// under random idling on both sides.
// ----------------------------------------------------------------------------
module stream_find_replace_test;

  localparam int CLK_HALF      = 2;
  localparam int SETTLE_CYCLES = 40;    // covers the controller latency of one item
  localparam int QUIET_LIMIT   = 1500;  // cycles without any transaction
  localparam int HOLD_OFF_LEN  = 200;   // long receiver stall in the pressure test
  localparam int RANDOM_ITEMS  = 265;
  localparam int MAX_PAT       = 8;
  localparam int MAX_REP       = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } sfr_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [sfr_pkg::CFG_IW-1:0] cfg_index;
  logic [sfr_pkg::CFG_DW-1:0] cfg_wdata;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [7:0]                 in_tdata;   // [7:0] text_byte
  logic                       in_tlast;   // text_end
  logic                       out_tvalid;
  logic                       out_tready;
  logic [7:0]                 out_tdata;  // [7:0] out_byte
  logic                       out_tuser;  // [0] out_has_byte
  logic                       out_tlast;  // out_last

  // Behavioral copy of the block: configuration and held-byte buffer
  logic [63:0] pat_word;
  logic [3:0]  pat_len_reg;
  logic [63:0] rep_word;
  logic [3:0]  rep_len_reg;
  logic [7:0]  held_buf [MAX_PAT];
  int          held_cnt;
  bit          held_old;     // held bytes belong to an earlier pattern

  sfr_result_t rewritten_q [$];  // predicted output transactions, oldest first

  // Bench bookkeeping
  int   error_count;
  int   bytes_sent;
  int   results_seen;
  int   match_count;
  int   settings_used;
  bit   idle_on;          // random gaps on both sides
  int   hold_off_cycles;  // request for one long receiver stall
  int   text_left;        // bytes left in the current random text
  logic [7:0] letters [3];
  logic [7:0] piece_q [$];

  stream_find_replace DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic int eff_pat_len();
    return (pat_len_reg > MAX_PAT) ? MAX_PAT : int'(pat_len_reg);
  endfunction

  function automatic void push_rewritten(logic [7:0] d, logic h);
    sfr_result_t r;
    r.data = d;
    r.has  = h;
    r.last = 1'b0;
    rewritten_q.push_back(r);
  endfunction

  // Release the oldest held byte and close the gap behind it
  function automatic void release_front_byte();
    int i;
    push_rewritten(held_buf[0], 1'b1);
    for (i = 0; i < MAX_PAT - 1; i++)
      held_buf[i] = held_buf[i + 1];
    held_cnt--;
  endfunction

  function automatic bit held_matches_pattern();
    int i;
    for (i = 0; i < held_cnt; i++)
      if (held_buf[i] != pat_word[8*i +: 8])
        return 1'b0;
    return 1'b1;
  endfunction

  // Work out the rewritten output caused by one accepted text byte
  function automatic void rewrite_text_byte(logic [7:0] b, logic text_end);
    int plen;
    int rlen;
    int n_before;
    int i;
    sfr_result_t tail;
    plen     = eff_pat_len();
    rlen     = (rep_len_reg > MAX_REP) ? MAX_REP : int'(rep_len_reg);
    n_before = rewritten_q.size();

    // Stale held bytes and pass-through both dump the buffer unmatched
    if (held_old || plen == 0) begin
      while (held_cnt > 0) release_front_byte();
      held_old = 1'b0;
    end

    if (plen == 0) begin
      push_rewritten(b, 1'b1);
    end else begin
      while (held_cnt >= plen) release_front_byte();
      held_buf[held_cnt] = b;
      held_cnt++;
      if (held_cnt == plen && held_matches_pattern()) begin
        for (i = 0; i < rlen; i++)
          push_rewritten(rep_word[8*i +: 8], 1'b1);
        held_cnt = 0;
        match_count++;
      end else begin
        while (held_cnt > 0 && !held_matches_pattern()) release_front_byte();
      end
    end

    if (text_end) begin
      while (held_cnt > 0) release_front_byte();
      if (rewritten_q.size() == n_before) begin
        push_rewritten(8'h00, 1'b0);
      end
      tail = rewritten_q.pop_back();
      tail.last = 1'b1;
      rewritten_q.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one text byte, optionally after a short idle burst, and wait for
  // the transaction; predict its output once accepted.
  task automatic send_text_byte(input logic [7:0] b, input logic text_end);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= text_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rewrite_text_byte(b, text_end);
    bytes_sent++;
  endtask

  // Stop offering, let every predicted result arrive, then let the
  // controller settle in case it still holds bytes that produce nothing.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; only call while the block is idle
  task automatic apply_setting(input logic [63:0] pat, input int plen,
                               input logic [63:0] rep, input int rlen);
    cfg_wr_en <= 1'b1;
    cfg_index <= sfr_pkg::CFG_PATTERN_BYTES;
    cfg_wdata <= pat;
    @(posedge clk);
    pat_word = pat;
    held_old = 1'b1;
    cfg_index <= sfr_pkg::CFG_PATTERN_LENGTH;
    cfg_wdata <= 64'(plen[3:0]);
    @(posedge clk);
    pat_len_reg = plen[3:0];
    cfg_index <= sfr_pkg::CFG_REPLACEMENT_BYTES;
    cfg_wdata <= rep;
    @(posedge clk);
    rep_word = rep;
    cfg_index <= sfr_pkg::CFG_REPLACEMENT_LENGTH;
    cfg_wdata <= 64'(rlen[3:0]);
    @(posedge clk);
    rep_len_reg = rlen[3:0];
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Queue the next chunk of random text: a whole pattern, a pattern prefix,
  // a byte from the phase alphabet or a fully random byte.
  task automatic fill_piece();
    int plen;
    int sel;
    int cut;
    int i;
    plen = eff_pat_len();
    sel  = $urandom_range(0, 9);
    if (plen > 0 && sel < 4) begin
      for (i = 0; i < plen; i++) piece_q.push_back(pat_word[8*i +: 8]);
    end else if (plen > 1 && sel < 6) begin
      cut = $urandom_range(1, plen - 1);
      for (i = 0; i < cut; i++) piece_q.push_back(pat_word[8*i +: 8]);
    end else if (sel < 8) begin
      piece_q.push_back(letters[$urandom_range(0, 2)]);
    end else begin
      piece_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Send a number of random text bytes; texts run on across calls
  task automatic send_random_bytes(input int count);
    int k;
    logic [7:0] b;
    for (k = 0; k < count; k++) begin
      if (text_left == 0)
        text_left = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24);
      if (piece_q.size() == 0) fill_piece();
      b = piece_q.pop_front();
      text_left--;
      send_text_byte(b, text_left == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset configuration is an empty pattern: bytes pass through unchanged
  task automatic test_pass_through();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b1);
    send_text_byte(8'hA5, 1'b1);   // one-byte text
    wait_for_results();
  endtask

  task automatic test_match_cases();
    // "ab" -> "XYZ": overlapping prefix "aab" releases one byte, then matches
    apply_setting(64'h6261, 2, 64'h5A5958, 3);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h62, 1'b1);
    // held prefix flushed at text end
    send_text_byte(8'h78, 1'b0);
    send_text_byte(8'h61, 1'b1);
    wait_for_results();

    // Oversized lengths clamp to eight bytes on both sides
    apply_setting(64'h8877665544332211, 15, 64'h00FF00FF00FF00FF, 15);
    send_text_byte(8'h11, 1'b0);
    send_text_byte(8'h22, 1'b0);
    send_text_byte(8'h33, 1'b0);
    send_text_byte(8'h44, 1'b0);
    send_text_byte(8'h55, 1'b0);
    send_text_byte(8'h66, 1'b0);
    send_text_byte(8'h77, 1'b0);
    send_text_byte(8'h88, 1'b1);
    wait_for_results();

    // Deletion of the final byte leaves only an end marker
    apply_setting(64'h5A, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_text_byte(8'h5A, 1'b1);
    wait_for_results();
  endtask

  // Change the pattern while a prefix is held; held bytes come out untouched
  task automatic test_stale_pattern();
    apply_setting(64'h636261, 3, 64'h51, 1);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h62, 1'b0);
    wait_for_results();
    apply_setting(64'h7A62, 2, 64'h51, 1);
    send_text_byte(8'h7A, 1'b1);
    wait_for_results();
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering,
  // so the block fills up and drops in_tready
  task automatic test_output_hold_off();
    int k;
    apply_setting(64'h61, 1, 64'h0102040810204080, 8);
    hold_off_cycles = HOLD_OFF_LEN;
    for (k = 0; k < 24; k++)
      send_text_byte(($urandom_range(0, 1) == 0) ? 8'h61 : 8'($urandom_range(0, 255)),
                     k == 23);
    wait_for_results();
  endtask

  task automatic test_random_texts();
    int sent;
    int batch;
    int phase;
    int plen;
    int rlen;
    int i;
    logic [63:0] pat;
    sent  = 0;
    phase = 0;
    text_left = 0;
    while (sent < RANDOM_ITEMS) begin
      for (i = 0; i < 3; i++) letters[i] = 8'($urandom_range(0, 255));
      case (phase)
        0:       begin plen = 0;  rlen = $urandom_range(0, 8); end
        1:       begin plen = 8;  rlen = 8;  end
        2:       begin plen = 15; rlen = 0;  end
        3:       begin plen = 1;  rlen = 15; end
        default: begin
          plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
          rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        end
      endcase
      for (i = 0; i < 8; i++) pat[8*i +: 8] = letters[$urandom_range(0, 2)];
      // pending pieces belong to the old pattern; keep them as noise
      wait_for_results();
      apply_setting(pat, plen, {$urandom, $urandom}, rlen);
      batch = $urandom_range(20, 40);
      if (RANDOM_ITEMS - sent <= 60) begin
        idle_on = 1'b0;   // final stretch runs back to back
        batch = RANDOM_ITEMS - sent;
      end
      send_random_bytes(batch);
      sent += batch;
      phase++;
    end
    if (text_left > 0) begin
      send_text_byte(8'($urandom_range(0, 255)), 1'b1);
      text_left = 0;
    end
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each output transaction with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    sfr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (rewritten_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual byte %02h has %0b last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = rewritten_q.pop_front();
        if (out_tdata !== want.data) begin
          error_count++;
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.data, out_tdata);
        end
        if (out_tuser !== want.has) begin
          error_count++;
          $display("%0t: out_has_byte mismatch: expected %0b, actual %0b",
                   $time, want.has, out_tuser);
        end
        if (out_tlast !== want.last) begin
          error_count++;
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_tlast);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results still expected",
             $time, QUIET_LIMIT, rewritten_q.size());
    $display("[stream_find_replace] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= sfr_pkg::CFG_PATTERN_BYTES;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;

    // model matches the reset state: empty pattern, nothing held
    pat_word      = '0;
    pat_len_reg   = '0;
    rep_word      = '0;
    rep_len_reg   = '0;
    held_cnt      = 0;
    held_old      = 1'b0;
    error_count   = 0;
    bytes_sent    = 0;
    results_seen  = 0;
    match_count   = 0;
    settings_used = 0;
    idle_on       = 1'b1;
    hold_off_cycles = 0;
    text_left     = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_pass_through();
    test_match_cases();
    test_stale_pattern();
    test_output_hold_off();
    test_random_texts();

    $display("Sent %0d text bytes under %0d register settings, %0d pattern matches.",
             bytes_sent, settings_used, match_count);
    $display("Checked %0d output transactions, %0d mismatches, %0d left unmatched.",
             results_seen, error_count, rewritten_q.size());
    if (error_count == 0 && rewritten_q.size() == 0) begin
      $display("[stream_find_replace] OK");
    end else begin
      $display("[stream_find_replace] ERROR");
    end
    $finish;
  end

endmodule
